// ===== hw/rtl/tccs_pkg.sv =====
// ----------------------------------------------------------------------------
// tccs_pkg
// types and constants shared by the text console blocks
// ----------------------------------------------------------------------------
package tccs_pkg;

	localparam int MODE_W     = 3;
	localparam int CHAR_W     = 8;
	localparam int MS_W       = 10;
	localparam int POS_W      = 11;
	localparam int PH_W       = 2;
	localparam int CELL_W     = 16;
	localparam int TMR_W      = 13;
	localparam int PER_W      = 12;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 12;

	// command codes
	localparam logic [MODE_W-1:0] MODE_PUT   = 3'd0;
	localparam logic [MODE_W-1:0] MODE_TICK  = 3'd1;
	localparam logic [MODE_W-1:0] MODE_CLEAR = 3'd2;
	localparam logic [MODE_W-1:0] MODE_SETC  = 3'd3;
	localparam logic [MODE_W-1:0] MODE_READ  = 3'd4;
	localparam logic [MODE_W-1:0] MODE_BLINK = 3'd5;

	// character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'd8;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'd9;
	localparam logic [CHAR_W-1:0] CH_NL    = 8'd10;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_MARK  = 8'h23;
	localparam logic [CHAR_W-1:0] ATTR_MARK = 8'd7;

	// blink phase codes
	localparam logic [PH_W-1:0] PHASE_OFF   = 2'd0;
	localparam logic [PH_W-1:0] PHASE_BLANK = 2'd1;
	localparam logic [PH_W-1:0] PHASE_MARK  = 2'd2;

	// register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_TEXT_COLOR   = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_BLINK_PERIOD = 1'b1;
	localparam logic [CHAR_W-1:0]    COLOR_RST  = 8'd7;
	localparam logic [PER_W-1:0]     PERIOD_RST = 12'd300;

	typedef struct packed {
		logic [MODE_W-1:0] mode;
		logic [CHAR_W-1:0] char_code;
		logic [MS_W-1:0]   elapsed_ms;
		logic [POS_W-1:0]  position;
		logic              blink_enable;
	} item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] cell_char;
		logic [CHAR_W-1:0] cell_attr;
		logic [POS_W-1:0]  cursor_pos;
		logic [PH_W-1:0]   blink_state;
	} result_t;

	typedef enum logic [4:0] {
		ST_INIT,
		ST_IDLE,
		ST_DECODE,
		ST_PUT,
		ST_MARK,
		ST_BS,
		ST_NL,
		ST_NL_DIV,
		ST_SCR,
		ST_SCR_FIX,
		ST_TICK,
		ST_CLR,
		ST_CLR_END,
		ST_SETC,
		ST_RD,
		ST_RD_CAP,
		ST_BLINK,
		ST_DONE
	} state_t;

	typedef enum logic [2:0] {
		WD_TEXT,
		WD_MARK,
		WD_BLANK,
		WD_BLINK
	} wd_sel_t;

	typedef enum logic [2:0] {
		CUR_HOLD,
		CUR_INC,
		CUR_DEC,
		CUR_NL,
		CUR_UP,
		CUR_ZERO,
		CUR_SET
	} cur_op_t;

	typedef enum logic [1:0] {
		PHOP_HOLD,
		PHOP_ON,
		PHOP_EN
	} ph_op_t;

	typedef enum logic [1:0] {
		SW_INIT,
		SW_CLEAR,
		SW_SCROLL
	} sw_kind_t;

	typedef struct packed {
		logic     accept;
		logic     wr_en;
		wd_sel_t  wd_sel;
		cur_op_t  cur_op;
		ph_op_t   ph_op;
		logic     rem_load;
		logic     rem_sub;
		logic     sweep_step;
		sw_kind_t sw_kind;
		logic     rd_cell;
		logic     rd_cap;
		logic     tick;
	} ctl_cmd_t;

	typedef struct packed {
		logic [MODE_W-1:0] item_mode;
		logic [CHAR_W-1:0] item_char;
		logic              cur_zero;
		logic              cur_past;
		logic              rem_ge;
		logic              sweep_last;
	} dp_stat_t;

endpackage

// ===== hw/rtl/tccs_ctrl.sv =====
// ----------------------------------------------------------------------------
// tccs_ctrl
// command sequencer: decodes a transaction and steps the datapath through it
// ----------------------------------------------------------------------------
module tccs_ctrl
	import tccs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	output logic     done,
	output ctl_cmd_t cmd,
	input  dp_stat_t stat
);

	state_t state_q, state_d;
	logic   tab_q, tab_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_INIT;
			tab_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			tab_q   <= tab_d;
		end
	end

	always_comb begin
		state_d = state_q;
		tab_d   = tab_q;
		cmd     = '0;
		busy    = 1'b1;
		done    = 1'b0;
		unique case (state_q)
			ST_INIT: begin
				cmd.sweep_step = 1'b1;
				cmd.sw_kind    = SW_INIT;
				if (stat.sweep_last) state_d = ST_IDLE;
			end
			ST_IDLE: begin
				busy  = 1'b0;
				tab_d = 1'b0;
				if (start) begin
					cmd.accept = 1'b1;
					state_d    = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (stat.item_mode)
					MODE_PUT: begin
						if (stat.item_char == CH_BS) begin
							state_d = stat.cur_zero ? ST_DONE : ST_BS;
						end else if (stat.item_char == CH_NL) begin
							state_d = ST_NL;
						end else begin
							tab_d   = (stat.item_char == CH_TAB);
							state_d = ST_PUT;
						end
					end
					MODE_TICK:  state_d = ST_TICK;
					MODE_CLEAR: state_d = ST_CLR;
					MODE_SETC:  state_d = ST_SETC;
					MODE_READ:  state_d = ST_RD;
					MODE_BLINK: state_d = ST_BLINK;
					default:    state_d = ST_DONE;
				endcase
			end
			ST_PUT: begin
				cmd.wr_en  = 1'b1;
				cmd.wd_sel = WD_TEXT;
				cmd.cur_op = CUR_INC;
				state_d    = ST_MARK;
			end
			ST_MARK: begin
				cmd.wr_en  = 1'b1;
				cmd.wd_sel = WD_MARK;
				cmd.ph_op  = PHOP_ON;
				if (stat.cur_past) begin
					state_d = ST_SCR;
				end else if (tab_q) begin
					tab_d   = 1'b0;
					state_d = ST_PUT;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_BS: begin
				cmd.wr_en  = 1'b1;
				cmd.wd_sel = WD_BLANK;
				cmd.cur_op = CUR_DEC;
				state_d    = ST_MARK;
			end
			ST_NL: begin
				cmd.wr_en    = 1'b1;
				cmd.wd_sel   = WD_BLANK;
				cmd.rem_load = 1'b1;
				state_d      = ST_NL_DIV;
			end
			ST_NL_DIV: begin
				if (stat.rem_ge) begin
					cmd.rem_sub = 1'b1;
				end else begin
					cmd.cur_op = CUR_NL;
					state_d    = ST_MARK;
				end
			end
			ST_SCR: begin
				cmd.sweep_step = 1'b1;
				cmd.sw_kind    = SW_SCROLL;
				if (stat.sweep_last) state_d = ST_SCR_FIX;
			end
			ST_SCR_FIX: begin
				cmd.cur_op = CUR_UP;
				state_d    = ST_MARK;
			end
			ST_TICK: begin
				cmd.tick = 1'b1;
				state_d  = ST_DONE;
			end
			ST_CLR: begin
				cmd.sweep_step = 1'b1;
				cmd.sw_kind    = SW_CLEAR;
				if (stat.sweep_last) state_d = ST_CLR_END;
			end
			ST_CLR_END: begin
				cmd.cur_op = CUR_ZERO;
				state_d    = ST_DONE;
			end
			ST_SETC: begin
				cmd.cur_op = CUR_SET;
				state_d    = ST_DONE;
			end
			ST_RD: begin
				cmd.rd_cell = 1'b1;
				state_d     = ST_RD_CAP;
			end
			ST_RD_CAP: begin
				cmd.rd_cap = 1'b1;
				state_d    = ST_DONE;
			end
			ST_BLINK: begin
				cmd.wr_en  = 1'b1;
				cmd.wd_sel = WD_BLINK;
				cmd.ph_op  = PHOP_EN;
				state_d    = ST_DONE;
			end
			ST_DONE: begin
				done    = 1'b1;
				state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

endmodule

// ===== hw/rtl/tccs_dp.sv =====
// ----------------------------------------------------------------------------
// tccs_dp
// cell store, cursor, blink timer, row remainder unit and sweep engine
// ----------------------------------------------------------------------------
module tccs_dp
	import tccs_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  ctl_cmd_t              cmd,
	output dp_stat_t              stat,
	input  item_t                 item,
	input  logic                  cfg_valid,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	output result_t               result
);

	localparam int CELLS = COLUMNS * ROWS;
	localparam int AW    = $clog2(CELLS);
	localparam int CW    = $clog2(CELLS + 1);
	localparam int XW    = (CW > POS_W) ? CW : POS_W;

	localparam logic [CW-1:0] CELLS_C  = CW'(CELLS);
	localparam logic [CW-1:0] COLS_C   = CW'(COLUMNS);
	localparam logic [XW-1:0] CELLS_X  = XW'(CELLS);
	localparam logic [AW-1:0] LAST_IDX = AW'(CELLS - 1);
	localparam logic [AW-1:0] BOT_IDX  = AW'(CELLS - COLUMNS);
	localparam logic [AW:0]   COLS_IDX = (AW + 1)'(COLUMNS);

	localparam logic [CELL_W-1:0] CELL_BLANK = {ATTR_MARK, CH_SPACE};
	localparam logic [CELL_W-1:0] CELL_MARK  = {ATTR_MARK, CH_MARK};

	logic [CELL_W-1:0] mem [0:CELLS-1];

	item_t             item_q;
	logic [CHAR_W-1:0] text_color_q;
	logic [PER_W-1:0]  period_q;
	logic [CW-1:0]     cursor_q;
	logic [PH_W-1:0]   phase_q;
	logic [TMR_W-1:0]  timer_q;
	logic [CW-1:0]     rem_q;
	logic [AW-1:0]     idx_q;
	logic [AW-1:0]     idx_s1;
	logic              v_s1;
	sw_kind_t          kind_s1;
	logic [CELL_W-1:0] rd_data_q;
	logic [CHAR_W-1:0] rd_char_q;
	logic [CHAR_W-1:0] rd_attr_q;

	logic              pos_ok;
	logic              cur_ok;
	logic [CHAR_W-1:0] text_ch;
	logic [CELL_W-1:0] cmd_wd;
	logic [TMR_W-1:0]  tmr_diff;
	logic              tick_live;
	logic              tick_fire;
	logic              we;
	logic [AW-1:0]     wa;
	logic [CELL_W-1:0] wd;
	logic              re;
	logic [AW-1:0]     ra;
	logic [AW:0]       scr_ra;

	assign pos_ok    = XW'(item_q.position) < CELLS_X;
	assign cur_ok    = cursor_q < CELLS_C;
	assign text_ch   = (item_q.char_code == CH_TAB) ? CH_SPACE : item_q.char_code;
	assign tmr_diff  = timer_q - TMR_W'(item_q.elapsed_ms);
	assign tick_live = cmd.tick && (phase_q != PHASE_OFF);
	assign tick_fire = tick_live && tmr_diff[TMR_W-1];
	assign scr_ra    = {1'b0, idx_q} + COLS_IDX;

	always_comb begin
		case (cmd.wd_sel)
			WD_TEXT:  cmd_wd = {text_color_q, text_ch};
			WD_MARK:  cmd_wd = CELL_MARK;
			WD_BLINK: cmd_wd = item_q.blink_enable ? CELL_MARK : CELL_BLANK;
			default:  cmd_wd = CELL_BLANK;
		endcase
	end

	// write port: sweep stage has priority, the sequencer never overlaps it
	always_comb begin
		we = 1'b0;
		wa = cursor_q[AW-1:0];
		wd = cmd_wd;
		if (v_s1) begin
			we = 1'b1;
			wa = idx_s1;
			case (kind_s1)
				SW_CLEAR:  wd = {rd_data_q[CELL_W-1:CHAR_W], CH_SPACE};
				SW_SCROLL: wd = (idx_s1 < BOT_IDX) ? rd_data_q : CELL_BLANK;
				default:   wd = CELL_BLANK;
			endcase
		end else if (tick_fire) begin
			we = cur_ok;
			wd = (phase_q == PHASE_MARK) ? CELL_MARK : CELL_BLANK;
		end else if (cmd.wr_en) begin
			we = cur_ok;
		end
	end

	always_comb begin
		re = 1'b0;
		ra = idx_q;
		if (cmd.sweep_step) begin
			re = 1'b1;
			if (cmd.sw_kind == SW_SCROLL && idx_q < BOT_IDX) ra = scr_ra[AW-1:0];
		end else if (cmd.rd_cell) begin
			re = pos_ok;
			ra = AW'(item_q.position);
		end
	end

	always_ff @(posedge clk) begin
		if (we) mem[wa] <= wd;
		if (re) rd_data_q <= mem[ra];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd.accept) item_q <= item;
		if (cmd.rem_load) begin
			rem_q <= cursor_q;
		end else if (cmd.rem_sub) begin
			rem_q <= rem_q - COLS_C;
		end
		idx_s1  <= idx_q;
		kind_s1 <= cmd.sw_kind;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			text_color_q <= COLOR_RST;
			period_q     <= PERIOD_RST;
			cursor_q     <= '0;
			phase_q      <= PHASE_BLANK;
			timer_q      <= '0;
			idx_q        <= '0;
			v_s1         <= 1'b0;
			rd_char_q    <= '0;
			rd_attr_q    <= '0;
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_TEXT_COLOR:   text_color_q <= cfg_data[CHAR_W-1:0];
					REG_BLINK_PERIOD: period_q     <= cfg_data[PER_W-1:0];
				endcase
			end

			case (cmd.cur_op)
				CUR_INC:  cursor_q <= cursor_q + 1'b1;
				CUR_DEC:  cursor_q <= cursor_q - 1'b1;
				CUR_NL:   cursor_q <= cursor_q - rem_q + COLS_C;
				CUR_UP:   cursor_q <= cursor_q - COLS_C;
				CUR_ZERO: cursor_q <= '0;
				CUR_SET:  if (pos_ok) cursor_q <= CW'(item_q.position);
				default:  cursor_q <= cursor_q;
			endcase

			if (tick_fire) begin
				phase_q <= (phase_q == PHASE_MARK) ? PHASE_BLANK : PHASE_MARK;
			end else if (cmd.ph_op == PHOP_ON) begin
				phase_q <= PHASE_BLANK;
			end else if (cmd.ph_op == PHOP_EN) begin
				phase_q <= item_q.blink_enable ? PHASE_BLANK : PHASE_OFF;
			end

			if (tick_live) timer_q <= tick_fire ? TMR_W'(period_q) : tmr_diff;

			if (cmd.sweep_step) idx_q <= (idx_q == LAST_IDX) ? '0 : idx_q + 1'b1;
			v_s1 <= cmd.sweep_step;

			if (cmd.accept) begin
				rd_char_q <= '0;
				rd_attr_q <= '0;
			end else if (cmd.rd_cap) begin
				rd_char_q <= pos_ok ? rd_data_q[CHAR_W-1:0] : '0;
				rd_attr_q <= pos_ok ? rd_data_q[CELL_W-1:CHAR_W] : '0;
			end
		end
	end

	assign stat.item_mode  = item_q.mode;
	assign stat.item_char  = item_q.char_code;
	assign stat.cur_zero   = (cursor_q == '0);
	assign stat.cur_past   = !cur_ok;
	assign stat.rem_ge     = (rem_q >= COLS_C);
	assign stat.sweep_last = (idx_q == LAST_IDX);

	assign result.cell_char   = rd_char_q;
	assign result.cell_attr   = rd_attr_q;
	assign result.cursor_pos  = POS_W'(cursor_q);
	assign result.blink_state = phase_q;

endmodule

// ===== hw/rtl/text_console_cursor_scroll.sv =====
// ----------------------------------------------------------------------------
// text_console_cursor_scroll
// text-mode console: character/attribute cell store with cursor, blink and scroll
// ----------------------------------------------------------------------------
// One command transaction is taken when start is high and busy is low; its
// single result appears on result for exactly one cycle with done high, and
// the receiver cannot hold it off. After reset the cell store is filled with
// space/attribute 7 by a clearing pass over all COLUMNS*ROWS cells, during
// which busy stays high; configuration writes are taken at any time. A
// newline runs the row remainder unit, which subtracts one row width per
// cycle. Any command that runs the cursor past the last cell adds a scroll,
// and clear sweeps every cell; both sweeps are paced by the single-write,
// single-read cell memory, which moves one cell per cycle.
// ----------------------------------------------------------------------------
module text_console_cursor_scroll
	import tccs_pkg::*;
#(
	parameter int COLUMNS = 80,
	parameter int ROWS    = 25
)
(
	input  logic                  clk,
	input  logic                  arst_n,
	// command channel
	input  logic                  start,
	output logic                  busy,
	input  item_t                 item,
	// result strobe
	output logic                  done,
	output result_t               result,
	// configuration write channel
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	ctl_cmd_t cmd;
	dp_stat_t stat;

	// registers are plain flops, a write transaction always completes
	assign cfg_ready = 1'b1;

	// sequencer: one state per step of a command
	tccs_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.stat   (stat)
	);

	// cell memory, cursor, blink state and the sweep used by reset, clear and scroll
	tccs_dp #(
		.COLUMNS (COLUMNS),
		.ROWS    (ROWS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.item      (item),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.result    (result)
	);

endmodule

// ===== hw/rtl/tccs_chk.sv =====
// ----------------------------------------------------------------------------
// tccs_chk
// port-level checks on the command and result handshake
// ----------------------------------------------------------------------------
module tccs_chk
	import tccs_pkg::*;
(
	input logic    clk,
	input logic    arst_n,
	input logic    start,
	input logic    busy,
	input logic    done,
	input result_t result
);

	// an accepted transaction keeps the block busy until its result
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("busy low after an accepted transaction");

	// result shows while the transaction is still open
	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> busy)
		else $error("done without an open transaction");

	// one strobe per transaction, then ready for the next
	a_done_single: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> (!done && !busy))
		else $error("done strobe longer than one cycle");

	// reported blink state is a valid phase
	a_blink_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (result.blink_state == PHASE_OFF || result.blink_state == PHASE_BLANK ||
			result.blink_state == PHASE_MARK))
		else $error("bad blink state in result");

endmodule

bind text_console_cursor_scroll tccs_chk u_tccs_chk (.*);
